// ----- rtl/lmfb_pkg.sv -----
// LED matrix frame buffer package: operation codes, controller command type,
// buffer geometry and the word bit-reverse helper.
// No dependencies.
package lmfb_pkg;

    localparam int NUM_COLUMNS = 8;
    localparam int COL_W       = $clog2(NUM_COLUMNS);
    localparam int ROW_COUNT   = 16;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int SHOW_BYTES  = 2 * NUM_COLUMNS;
    localparam int BYTE_IDX_W  = $clog2(SHOW_BYTES);
    localparam int MASK_W      = NUM_COLUMNS;
    localparam int OP_W        = 2;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_SET_PIXEL = 2'd0,
        OP_WRITE_ROW = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_SHOW      = 2'd3
    } op_t;

    // Register indexes (taken from paddr[2])
    localparam logic REG_HFLIP = 1'b0;
    localparam logic REG_VFLIP = 1'b1;

    typedef logic [ROW_COUNT-1:0] col_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                  apply;     // apply a buffer-update request
        logic                  load_out;  // load next show byte into output register
        logic [BYTE_IDX_W-1:0] byte_sel;  // which show byte
        logic                  last;      // this byte closes the show
    } lmfb_cmd_t;

    function automatic col_word_t reverse_word(input col_word_t w);
        col_word_t r;
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            r[i] = w[ROW_COUNT-1-i];
        end
        return r;
    endfunction

endpackage

// ----- rtl/led_matrix_frame_buffer_core.sv -----
// LED matrix frame buffer top level. Pixel, row and clear requests are
// accepted back to back. A show request emits 16 bytes: the controller enters
// its show state, then loads the bytes into the output register one per cycle
// while m_axis_tready is high. The byte counter in the controller counts them,
// and a show holds the input until its last byte is loaded. Reset clears the
// pixel store and both flip registers. Depends on lmfb_pkg, lmfb_ctrl, lmfb_dp.
module led_matrix_frame_buffer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] row_index, [6:4] column_index, [7] pixel_value,
    // [15:8] row_mask, [16] direct_columns, [23:17] zero
    input  logic [lmfb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] operation
    input  logic [lmfb_pkg::OP_W-1:0]           s_axis_tuser,
    // Output byte stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] display_byte
    output logic [lmfb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lmfb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lmfb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lmfb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lmfb_pkg::*;

    lmfb_cmd_t cmd;
    logic      hflip_reg;
    logic      vflip_reg;
    logic      cfg_wr;
    logic      reg_sel;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hflip_reg <= 1'b0;
            vflip_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_HFLIP: hflip_reg <= pwdata[0];
                REG_VFLIP: vflip_reg <= pwdata[0];
                default:   hflip_reg <= hflip_reg;
            endcase
        end
    end

    assign prdata = (reg_sel == REG_VFLIP) ? APB_DATA_W'(vflip_reg)
                                           : APB_DATA_W'(hflip_reg);

    lmfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    lmfb_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_op           (s_axis_tuser),
        .row_index       (s_axis_tdata[3:0]),
        .column_index    (s_axis_tdata[6:4]),
        .pixel_value     (s_axis_tdata[7]),
        .row_mask        (s_axis_tdata[15:8]),
        .direct_columns  (s_axis_tdata[16]),
        .horizontal_flip (hflip_reg),
        .vertical_flip   (vflip_reg),
        .display_byte    (m_axis_tdata),
        .last_byte       (m_axis_tlast)
    );

    // A show request blocks the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SHOW) |=> !s_axis_tready)
        else $error("input not blocked after show request");

    // Buffer updates leave the input open on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_SHOW) |=> s_axis_tready)
        else $error("input blocked after update request");

    // A pending byte that is not the last one means a show is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input open in the middle of a show");

endmodule

// ----- rtl/lmfb_ctrl.sv -----
// LED matrix frame buffer controller: idle/show state machine, show byte
// counter and output valid flag. Depends on lmfb_pkg.
module lmfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [lmfb_pkg::OP_W-1:0] in_op,
    output logic                out_valid,
    input  logic                out_ready,
    output lmfb_pkg::lmfb_cmd_t cmd
);
    import lmfb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } state_t;

    localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(SHOW_BYTES - 1);

    state_t                state_reg, state_next;
    logic [BYTE_IDX_W-1:0] count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  out_free;
    logic                  load;
    op_t                   op;

    assign op       = op_t'(in_op);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load     = (state_reg == ST_SHOW) && out_free;

    // Next state and byte counter
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_SHOW)
                begin
                    state_next = ST_SHOW;
                    count_next = '0;
                end
            end
            ST_SHOW:
            begin
                if (load)
                begin
                    count_next = count_reg + 1'b1;
                    if (count_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cmd.apply     = accept && (op != OP_SHOW);
    assign cmd.load_out  = load;
    assign cmd.byte_sel  = count_reg;
    assign cmd.last      = (count_reg == LAST_IDX);

endmodule

// ----- rtl/lmfb_dp.sv -----
// LED matrix frame buffer datapath: 8x16 pixel store, update logic and the
// show byte output register. Depends on lmfb_pkg.
module lmfb_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lmfb_pkg::lmfb_cmd_t                cmd,
    input  logic [lmfb_pkg::OP_W-1:0]          in_op,
    input  logic [lmfb_pkg::ROW_W-1:0]         row_index,
    input  logic [lmfb_pkg::COL_W-1:0]         column_index,
    input  logic                               pixel_value,
    input  logic [lmfb_pkg::MASK_W-1:0]        row_mask,
    input  logic                               direct_columns,
    input  logic                               horizontal_flip,
    input  logic                               vertical_flip,
    output logic [lmfb_pkg::OUT_DATA_W-1:0]    display_byte,
    output logic                               last_byte
);
    import lmfb_pkg::*;

    col_word_t                frame_reg  [NUM_COLUMNS];
    col_word_t                frame_next [NUM_COLUMNS];
    logic [OUT_DATA_W-1:0]    byte_reg, byte_next;
    logic                     last_reg;
    logic [COL_W-1:0]         pix_col;
    logic [COL_W-1:0]         show_col;
    col_word_t                show_word;
    op_t                      op;

    assign op      = op_t'(in_op);
    assign pix_col = direct_columns ? column_index : ~column_index;

    // Buffer update for pixel, row and clear requests
    always_comb
    begin
        for (int j = 0; j < NUM_COLUMNS; j++)
        begin
            frame_next[j] = frame_reg[j];
            if (cmd.apply)
            begin
                unique case (op)
                    OP_SET_PIXEL:
                    begin
                        if (pix_col == COL_W'(j))
                        begin
                            frame_next[j][row_index] = pixel_value;
                        end
                    end
                    OP_WRITE_ROW:
                    begin
                        frame_next[j][row_index] =
                            direct_columns ? row_mask[j] : row_mask[NUM_COLUMNS-1-j];
                    end
                    OP_CLEAR:
                    begin
                        frame_next[j] = '0;
                    end
                    OP_SHOW:
                    begin
                        frame_next[j] = frame_reg[j];
                    end
                    default:
                    begin
                        frame_next[j] = frame_reg[j];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_COLUMNS; j++)
            begin
                frame_reg[j] <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < NUM_COLUMNS; j++)
            begin
                frame_reg[j] <= frame_next[j];
            end
        end
    end

    // Show byte select: column order, word reverse, low then high half
    assign show_col  = horizontal_flip ? ~cmd.byte_sel[BYTE_IDX_W-1:1]
                                       : cmd.byte_sel[BYTE_IDX_W-1:1];
    assign show_word = vertical_flip ? reverse_word(frame_reg[show_col])
                                     : frame_reg[show_col];
    assign byte_next = cmd.byte_sel[0] ? show_word[ROW_COUNT-1:OUT_DATA_W]
                                       : show_word[OUT_DATA_W-1:0];

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            byte_reg <= byte_next;
            last_reg <= cmd.last;
        end
    end

    assign display_byte = byte_reg;
    assign last_byte    = last_reg;

endmodule

// ----- verif/led_matrix_frame_buffer_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for led_matrix_frame_buffer_core: random and directed buffer requests,
// flip settings over the register port, every show byte checked against a predictor.
// Depends on lmfb_pkg and led_matrix_frame_buffer_core.
module led_matrix_frame_buffer_core_tb;

    import lmfb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 80;
    localparam int IDLE_LIMIT    = 1000;
    localparam int PHASE_ITEMS   = 19;

    // Expected display bytes and the frame they are drawn from
    class frame_scoreboard;
        logic [ROW_COUNT-1:0] frame[NUM_COLUMNS];
        logic                 hflip;
        logic                 vflip;
        logic [8:0]           show_bytes_due[$];   // {last, byte}
        int                   errors;

        function new();
            foreach (frame[i])
            begin
                frame[i] = '0;
            end
            hflip  = 1'b0;
            vflip  = 1'b0;
            errors = 0;
        endfunction

        function void note_register(logic index, logic [APB_DATA_W-1:0] value);
            if (index == REG_HFLIP)
            begin
                hflip = value[0];
            end
            else
            begin
                vflip = value[0];
            end
        endfunction

        function void put_pixel(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                logic lit, logic direct);
            logic [COL_W-1:0] slot;
            slot = direct ? col : 3'd7 - col;
            frame[slot][row] = lit;
        endfunction

        // Apply one accepted request; a show queues its 16 bytes
        function void note_request(op_t op, logic [IN_DATA_W-1:0] data);
            logic [ROW_W-1:0]     row;
            logic [COL_W-1:0]     col;
            logic                 lit;
            logic [MASK_W-1:0]    mask;
            logic                 direct;
            logic [ROW_COUNT-1:0] word;
            int                   slot;
            row    = data[3:0];
            col    = data[6:4];
            lit    = data[7];
            mask   = data[15:8];
            direct = data[16];
            case (op)
                OP_SET_PIXEL: put_pixel(row, col, lit, direct);
                OP_WRITE_ROW:
                begin
                    for (int c = 0; c < NUM_COLUMNS; c++)
                    begin
                        put_pixel(row, c[COL_W-1:0], mask[c], direct);
                    end
                end
                OP_CLEAR:
                begin
                    foreach (frame[i])
                    begin
                        frame[i] = '0;
                    end
                end
                default:
                begin
                    for (int k = 0; k < NUM_COLUMNS; k++)
                    begin
                        slot = hflip ? NUM_COLUMNS - 1 - k : k;
                        word = frame[slot];
                        if (vflip)
                        begin
                            word = {<<{word}};
                        end
                        show_bytes_due.push_back({1'b0, word[7:0]});
                        show_bytes_due.push_back({k == NUM_COLUMNS - 1, word[15:8]});
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_byte(logic [OUT_DATA_W-1:0] got_byte, logic got_last);
            logic [8:0] want;
            if (show_bytes_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", got_byte, got_last));
            end
            else
            begin
                want = show_bytes_due.pop_front();
                if (got_byte !== want[7:0])
                begin
                    report_mismatch($sformatf("display byte %02h, want %02h",
                                              got_byte, want[7:0]));
                end
                if (got_last !== want[8])
                begin
                    report_mismatch($sformatf("last flag %0b, want %0b", got_last, want[8]));
                end
            end
        endtask

        function int pending();
            return show_bytes_due.size();
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_scoreboard board = new();
    bit              steady_flow;         // no idling on either side
    bit              long_hold_pending;   // receiver holds off once
    int              idle_cycles;

    led_matrix_frame_buffer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // Watchdog: give up after a long stretch with no transfer anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("led_matrix_frame_buffer_core_tb NOT OK");
                $finish;
            end
        end
    end

    // Byte receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_pending)
            begin
                gap = LONG_HOLD;
                long_hold_pending = 1'b0;
            end
            else
            begin
                gap = steady_flow ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            board.check_byte(m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_fields(logic [ROW_W-1:0] row,
                                                         logic [COL_W-1:0] col,
                                                         logic lit,
                                                         logic [MASK_W-1:0] mask,
                                                         logic direct);
        return {7'd0, direct, mask, lit, col, row};
    endfunction

    // Offer one request from a falling edge; returns at the falling edge after acceptance
    task send_request(op_t op, logic [IN_DATA_W-1:0] data);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge clk); while (!s_axis_tready);
        board.note_request(op, data);
        @(negedge clk);
    endtask

    task send_random_request();
        int   pick;
        op_t  op;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            op = OP_SET_PIXEL;
        end
        else if (pick < 65)
        begin
            op = OP_WRITE_ROW;
        end
        else if (pick < 73)
        begin
            op = OP_CLEAR;
        end
        else
        begin
            op = OP_SHOW;
        end
        send_request(op, pack_fields(ROW_W'($urandom), COL_W'($urandom), 1'($urandom),
                                     MASK_W'($urandom), 1'($urandom)));
    endtask

    // Register write, starting and ending at a falling edge
    task write_register(logic index, logic bit_value);
        logic [APB_DATA_W-1:0] value;
        value    = {$urandom} & ~32'd1;   // upper bits are don't-care
        value[0] = bit_value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.note_register(index, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every show byte is out and the block has gone quiet
    task drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [1:0] flip_plan[5];
        flip_plan = '{2'b01, 2'b10, 2'b11, 2'b00, 2'b11};   // {vflip, hflip}
        idle_cycles = 0;
        steady_flow = 1'b0;
        long_hold_pending = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: ignored fields, mirroring, pixel extremes, row masks, clear
        send_request(OP_CLEAR, pack_fields(4'hF, 3'd7, 1'b1, 8'hFF, 1'b1));
        send_request(OP_SHOW, pack_fields(4'hF, 3'd7, 1'b1, 8'hFF, 1'b1));
        send_request(OP_SET_PIXEL, pack_fields(4'd0, 3'd0, 1'b1, 8'h00, 1'b0));
        send_request(OP_SET_PIXEL, pack_fields(4'd15, 3'd7, 1'b1, 8'h00, 1'b0));
        send_request(OP_SET_PIXEL, pack_fields(4'd15, 3'd7, 1'b1, 8'hFF, 1'b1));
        send_request(OP_SET_PIXEL, pack_fields(4'd0, 3'd0, 1'b1, 8'hFF, 1'b1));
        send_request(OP_SHOW, '0);
        send_request(OP_SET_PIXEL, pack_fields(4'd0, 3'd0, 1'b0, 8'hFF, 1'b1));
        send_request(OP_WRITE_ROW, pack_fields(4'd0, 3'd5, 1'b0, 8'hFF, 1'b0));
        send_request(OP_WRITE_ROW, pack_fields(4'd15, 3'd0, 1'b1, 8'hA5, 1'b1));
        send_request(OP_WRITE_ROW, pack_fields(4'd8, 3'd2, 1'b0, 8'h5A, 1'b0));
        send_request(OP_WRITE_ROW, pack_fields(4'd7, 3'd7, 1'b1, 8'h00, 1'b1));
        send_request(OP_SHOW, pack_fields(4'd3, 3'd1, 1'b0, 8'h3C, 1'b0));
        send_request(OP_WRITE_ROW, pack_fields(4'd3, 3'd4, 1'b1, 8'h81, 1'b0));
        send_request(OP_SHOW, '0);
        send_request(OP_CLEAR, '0);
        send_request(OP_SHOW, '0);
        drain();

        // Random phases, one flip setting each
        for (int phase = 0; phase < 5; phase++)
        begin
            write_register(REG_HFLIP, flip_plan[phase][0]);
            write_register(REG_VFLIP, flip_plan[phase][1]);
            steady_flow = (phase == 3);
            if (phase == 1)
            begin
                long_hold_pending = 1'b1;
            end
            send_request(OP_SHOW, '0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_random_request();
            end
            send_request(OP_SHOW, '0);
            drain();
        end

        if (board.errors == 0)
        begin
            $display("led_matrix_frame_buffer_core_tb OK");
        end
        else
        begin
            $display("led_matrix_frame_buffer_core_tb NOT OK");
        end
        $finish;
    end

endmodule
